FILE: src/rld_pkg.sv
// rld_pkg: shared constants, payload structs, lane command struct and state type
// for the root-L1 descriptor normaliser. No dependencies.
package rld_pkg;

    localparam int DESCRIPTOR_LENGTH = 128;
    localparam int ELEM_W    = 16;
    localparam int PAIR_CAP  = (DESCRIPTOR_LENGTH + 1) / 2;
    localparam int PAIR_W    = (PAIR_CAP > 1) ? $clog2(PAIR_CAP) : 1;
    localparam int COUNT_W   = PAIR_W + 1;
    localparam int NORM_W    = ELEM_W + $clog2(DESCRIPTOR_LENGTH);
    localparam int TARGET_W  = 3 * ELEM_W;
    localparam int ACC_W     = 2 * ELEM_W + NORM_W + 1;
    localparam int BIT_W     = $clog2(ELEM_W);

    typedef struct packed {
        logic [ELEM_W-1:0] value_even;
        logic [ELEM_W-1:0] value_odd;
        logic              last_pair;
    } rld_in_t;

    typedef struct packed {
        logic [ELEM_W-1:0] root_even;
        logic [ELEM_W-1:0] root_odd;
        logic              end_of_descriptor;
    } rld_out_t;

    // per-lane command from the sequencer
    typedef struct packed {
        logic              wr_en;
        logic [PAIR_W-1:0] wr_addr;
        logic [ELEM_W-1:0] wr_data;
        logic [PAIR_W-1:0] rd_addr;
        logic              start;
    } rld_lane_cmd_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FETCH,
        ST_START,
        ST_CALC,
        ST_EMIT
    } rld_state_t;

    // odd element of a pair lies inside the descriptor
    function automatic logic odd_ok(input logic [COUNT_W-1:0] pair);
        return (2 * int'(pair) + 1) < DESCRIPTOR_LENGTH;
    endfunction

endpackage

FILE: src/rld_lane.sv
// rld_lane: one element bank plus a bit-serial root-quotient engine.
// Depends on rld_pkg.
module rld_lane (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rld_pkg::rld_lane_cmd_t      cmd,
    input  logic [rld_pkg::NORM_W-1:0]  norm,
    output logic                        done,
    output logic [rld_pkg::ELEM_W-1:0]  root
);

    logic [rld_pkg::ELEM_W-1:0]   mem [rld_pkg::PAIR_CAP];
    logic [rld_pkg::ELEM_W-1:0]   rdata_reg;
    logic [rld_pkg::TARGET_W-1:0] target_reg, target_next;
    logic [rld_pkg::ACC_W-1:0]    p_reg, p_next;
    logic [rld_pkg::ACC_W-1:0]    rn_reg, rn_next;
    logic [rld_pkg::ELEM_W-1:0]   r_reg, r_next;
    logic [rld_pkg::BIT_W-1:0]    bit_reg, bit_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [rld_pkg::ACC_W-1:0]    norm_ext;
    logic [rld_pkg::ACC_W-1:0]    cand;

    // element bank, registered read
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[cmd.wr_addr] <= cmd.wr_data;
        end
        rdata_reg <= mem[cmd.rd_addr];
    end

    // candidate (r | 2^b)^2 * norm built from running r^2*norm and r*norm
    assign norm_ext = rld_pkg::ACC_W'(norm);
    assign cand = p_reg + (rn_reg << (32'(bit_reg) + 1)) + (norm_ext << (2 * 32'(bit_reg)));

    always_comb begin
        target_next = target_reg;
        p_next      = p_reg;
        rn_next     = rn_reg;
        r_next      = r_reg;
        bit_next    = bit_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (cmd.start) begin
            target_next = {rdata_reg, {(2 * rld_pkg::ELEM_W){1'b0}}};
            p_next      = '0;
            rn_next     = '0;
            r_next      = '0;
            bit_next    = rld_pkg::BIT_W'(rld_pkg::ELEM_W - 1);
            busy_next   = 1'b1;
        end else if (busy_reg) begin
            if (cand <= rld_pkg::ACC_W'(target_reg)) begin
                p_next  = cand;
                rn_next = rn_reg + (norm_ext << 32'(bit_reg));
                r_next  = r_reg | (rld_pkg::ELEM_W'(1) << bit_reg);
            end
            if (bit_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                bit_next = bit_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        target_reg <= target_next;
        p_reg      <= p_next;
        rn_reg     <= rn_next;
        r_reg      <= r_next;
        bit_reg    <= bit_next;
    end

    assign done = done_reg;
    assign root = r_reg;

endmodule

FILE: src/root_l1_descriptor_normalizer.sv
// root_l1_descriptor_normalizer: top level, load sequencer, two lanes and merge stage.
// Depends on rld_pkg and rld_lane.
//
//  channel | ports                      | direction | carries
//  s_      | s_valid s_ready s_data     | in        | element pair, last mark
//  m_      | m_valid m_ready m_data     | out       | root pair, end of descriptor
//
// During loading s_ready stays high; the L1 norm is summed as pairs are stored.
// After the last pair, each result pair goes through bank read, engine start,
// 16 iterations of the bit-serial root search (one result bit per cycle), the
// engine's registered done flag, capture in the merge register, and output.
// Both lanes run the search together, so the 16-step loop sets the output rate.
// Input is not taken while results are emitted; a stalled output simply holds.
// Reset (aresetn low, synchronous) returns to loading and empties the norm, pair count and result index.
module root_l1_descriptor_normalizer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rld_pkg::rld_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rld_pkg::rld_out_t m_data
);

    rld_pkg::rld_state_t         state_reg, state_next;
    logic [rld_pkg::COUNT_W-1:0] fill_reg, fill_next;
    logic [rld_pkg::NORM_W-1:0]  norm_reg, norm_next;
    logic [rld_pkg::PAIR_W-1:0]  k_reg, k_next;
    rld_pkg::rld_out_t           out_reg, out_next;

    rld_pkg::rld_lane_cmd_t      cmd_even, cmd_odd;
    logic                        done_even, done_odd;
    logic [rld_pkg::ELEM_W-1:0]  root_even, root_odd;

    logic s_xfer, m_xfer, store_ok, odd_store, last_k, start;

    assign s_xfer    = s_valid && s_ready;
    assign m_xfer    = m_valid && m_ready;
    assign store_ok  = fill_reg < rld_pkg::COUNT_W'(rld_pkg::PAIR_CAP);
    assign odd_store = store_ok && rld_pkg::odd_ok(fill_reg);
    assign last_k    = (rld_pkg::COUNT_W'(k_reg) + 1'b1) == fill_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rld_pkg::ST_LOAD:  if (s_xfer && s_data.last_pair) state_next = rld_pkg::ST_FETCH;
            rld_pkg::ST_FETCH: state_next = rld_pkg::ST_START;
            rld_pkg::ST_START: state_next = rld_pkg::ST_CALC;
            rld_pkg::ST_CALC:  if (done_even) state_next = rld_pkg::ST_EMIT;
            rld_pkg::ST_EMIT: begin
                if (m_xfer) begin
                    state_next = last_k ? rld_pkg::ST_LOAD : rld_pkg::ST_FETCH;
                end
            end
            default: state_next = rld_pkg::ST_LOAD;
        endcase
    end

    // handshake outputs
    always_comb begin
        s_ready = 1'b0;
        m_valid = 1'b0;
        start   = 1'b0;
        case (state_reg)
            rld_pkg::ST_LOAD:  s_ready = 1'b1;
            rld_pkg::ST_START: start   = 1'b1;
            rld_pkg::ST_EMIT:  m_valid = 1'b1;
            default: ;
        endcase
    end

    // lane commands: write on load, read at the current result pair
    always_comb begin
        cmd_even.wr_en   = s_xfer && store_ok;
        cmd_even.wr_addr = fill_reg[rld_pkg::PAIR_W-1:0];
        cmd_even.wr_data = s_data.value_even;
        cmd_even.rd_addr = k_reg;
        cmd_even.start   = start;
        cmd_odd          = cmd_even;
        cmd_odd.wr_en    = s_xfer && odd_store;
        cmd_odd.wr_data  = s_data.value_odd;
    end

    // counters, norm and merge register
    always_comb begin
        fill_next = fill_reg;
        norm_next = norm_reg;
        k_next    = k_reg;
        out_next  = out_reg;
        if (s_xfer) begin
            if (store_ok) begin
                fill_next = fill_reg + 1'b1;
                norm_next = norm_reg + rld_pkg::NORM_W'(s_data.value_even)
                          + (odd_store ? rld_pkg::NORM_W'(s_data.value_odd) : '0);
            end
            k_next = '0;
        end
        if (state_reg == rld_pkg::ST_CALC && done_even && done_odd) begin
            out_next.root_even = (norm_reg == '0) ? '0 : root_even;
            out_next.root_odd  = (norm_reg == '0 ||
                                  !rld_pkg::odd_ok(rld_pkg::COUNT_W'(k_reg))) ? '0 : root_odd;
            out_next.end_of_descriptor = last_k;
        end
        if (m_xfer) begin
            if (last_k) begin
                fill_next = '0;
                norm_next = '0;
            end else begin
                k_next = k_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rld_pkg::ST_LOAD;
            fill_reg  <= '0;
            norm_reg  <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            norm_reg  <= norm_next;
            k_reg     <= k_next;
        end
        out_reg <= out_next;
    end

    assign m_data = out_reg;

    // even and odd lanes
    rld_lane u_lane_even (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd_even),
        .norm    (norm_reg),
        .done    (done_even),
        .root    (root_even)
    );

    rld_lane u_lane_odd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd_odd),
        .norm    (norm_reg),
        .done    (done_odd),
        .root    (root_odd)
    );

endmodule

FILE: sim/testbench.sv
// testbench: self-checking bench for root_l1_descriptor_normalizer, with its own root-L1 predictor
// and a queue of expected root pairs. Depends on rld_pkg and the block's RTL.
module testbench;

    localparam int CAP = (rld_pkg::DESCRIPTOR_LENGTH + 1) / 2;
    localparam int LIMIT_CYCLES = 2000000;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    rld_pkg::rld_in_t  s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    rld_pkg::rld_out_t m_data;

    // predictor state
    logic [15:0] elem_buf [0:127];
    logic [22:0] norm_acc = '0;
    int          pairs_held = 0;

    rld_pkg::rld_out_t roots_due [$];
    int  mismatches = 0;
    int  cycle_count = 0;
    bit  stall_m = 1'b1;
    bit  stall_s = 1'b1;

    root_l1_descriptor_normalizer uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #2 aclk = ~aclk;

    // floor of the Q0.16 root of elem / norm, saturated
    function automatic logic [15:0] q16_root(input logic [15:0] elem, input logic [22:0] norm);
        logic [15:0] r;
        logic [15:0] t;
        logic [63:0] goal;
        r = '0;
        if (norm == 0) return '0;
        goal = {16'd0, elem, 32'd0};
        for (int b = 15; b >= 0; b--) begin
            t = r | (16'd1 << b);
            if (64'(t) * 64'(t) * 64'(norm) <= goal) r = t;
        end
        return r;
    endfunction

    // update the model with one accepted pair and queue any roots it releases
    task automatic predict_pair(input rld_pkg::rld_in_t p);
        rld_pkg::rld_out_t o;
        if (pairs_held < CAP) begin
            elem_buf[2*pairs_held] = p.value_even;
            norm_acc = norm_acc + p.value_even;
            if (2*pairs_held + 1 < rld_pkg::DESCRIPTOR_LENGTH) begin
                elem_buf[2*pairs_held+1] = p.value_odd;
                norm_acc = norm_acc + p.value_odd;
            end
            pairs_held++;
        end
        if (p.last_pair) begin
            for (int k = 0; k < pairs_held; k++) begin
                o.root_even = q16_root(elem_buf[2*k], norm_acc);
                o.root_odd = (2*k + 1 < rld_pkg::DESCRIPTOR_LENGTH) ?
                             q16_root(elem_buf[2*k+1], norm_acc) : 16'd0;
                o.end_of_descriptor = (k + 1 == pairs_held);
                roots_due = {roots_due, o};
            end
            norm_acc = '0;
            pairs_held = 0;
        end
    endtask

    // send one transfer, with an optional idle burst first
    // valid stays high across back-to-back transfers and drops only for idling
    task automatic send_pair(input logic [15:0] ev, input logic [15:0] od, input logic lst);
        rld_pkg::rld_in_t p;
        p.value_even = ev;
        p.value_odd = od;
        p.last_pair = lst;
        if (stall_s && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= p;
        do @(posedge aclk); while (!s_ready);
        predict_pair(p);
        @(negedge aclk);
    endtask

    // a random descriptor of n pairs; mode picks value style
    task automatic send_descriptor(input int n, input int mode);
        logic [15:0] a;
        logic [15:0] b;
        for (int i = 0; i < n; i++) begin
            case (mode)
                0: begin a = 16'($urandom); b = 16'($urandom); end
                1: begin a = 16'($urandom_range(0, 255)); b = 16'($urandom_range(0, 255)); end
                default: begin
                    a = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'd0;
                    b = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'd0;
                end
            endcase
            send_pair(a, b, i == n - 1);
        end
    endtask

    // drop valid and wait for every queued root
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (roots_due.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    // output side: random back-pressure and comparison at the rising edge
    always @(negedge aclk) begin
        if (stall_m && $urandom_range(0, 3) == 0) begin
            m_ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge aclk);
        end
        m_ready <= 1'b1;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn && m_valid && m_ready) begin
            if (roots_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transfer %p", m_data);
            end else begin
                if (m_data !== roots_due[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", roots_due[0], m_data);
                end
                void'(roots_due.pop_front());
            end
        end
    end

    // generous limit
    always @(posedge aclk) begin
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAIL root_l1_descriptor_normalizer");
            $finish;
        end
    end

    // single-pair and two-pair descriptors at the field extremes, including zero norm and full scale
    task automatic test_extremes();
        send_pair(16'd0, 16'd0, 1'b1);
        send_pair(16'hFFFF, 16'd0, 1'b1);
        send_pair(16'd0, 16'hFFFF, 1'b1);
        send_pair(16'hFFFF, 16'hFFFF, 1'b1);
        send_pair(16'hAAAA, 16'h5555, 1'b0);
        send_pair(16'h5555, 16'hAAAA, 1'b1);
        send_pair(16'd1, 16'd0, 1'b0);
        send_pair(16'd0, 16'd0, 1'b1);
    endtask

    // a descriptor that fills the store, last mark on an ignored extra pair
    task automatic test_full_and_overlong();
        send_descriptor(CAP + 1, 0);
    endtask

    // short random descriptors with idling on both sides, then a drain pause and more short descriptors
    task automatic test_random_short();
        for (int i = 0; i < 6; i++) send_descriptor($urandom_range(1, 6), $urandom_range(0, 2));
        wait_drained();
        for (int i = 0; i < 3; i++) send_descriptor($urandom_range(1, 4), $urandom_range(0, 1));
    endtask

    // closing part without idling
    task automatic test_no_idle();
        stall_s = 1'b0;
        stall_m = 1'b0;
        for (int i = 0; i < 4; i++) send_descriptor($urandom_range(1, 5), $urandom_range(0, 2));
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_extremes();
        test_full_and_overlong();
        test_random_short();
        test_no_idle();
        wait_drained();
        if (mismatches == 0 && roots_due.size() == 0)
            $display("PASS root_l1_descriptor_normalizer");
        else
            $display("FAIL root_l1_descriptor_normalizer");
        $finish;
    end
endmodule
